FILE: rtl/pli_pkg.sv
package pli_pkg;

    localparam int MaxPoints = 64;
    localparam int IdxW      = 6;
    localparam int CountW    = 7;
    localparam int DataW     = 32;
    localparam int DivW      = 34;   // magnitude of a 33-bit difference plus margin
    localparam int ProdW     = 66;   // product of two 33-bit magnitudes
    localparam int QuotW     = 41;   // quotient kept up to 2^40

    localparam logic [1:0] StatusInside = 2'd0;
    localparam logic [1:0] StatusBelow  = 2'd1;
    localparam logic [1:0] StatusAbove  = 2'd2;

    localparam logic OpLoad  = 1'b0;
    localparam logic OpQuery = 1'b1;

    localparam logic RegPointCount  = 1'b0;
    localparam logic RegClampEnable = 1'b1;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_RD0    = 10'b0000000010,
        ST_RDLAST = 10'b0000000100,
        ST_CLASS  = 10'b0000001000,
        ST_SEARCH = 10'b0000010000,
        ST_RDSEG  = 10'b0000100000,
        ST_SETUP  = 10'b0001000000,
        ST_MUL    = 10'b0010000000,
        ST_DIV    = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

endpackage

FILE: rtl/piecewise_linear_interpolator_top.sv
// sequence: a load writes one table entry and gives no result; a query reads entry 0 and
// the last entry, classifies x, takes up to point_count - 2 search steps, reads both
// segment ends through one table read port, then runs a 32-step shift-add multiply and
// a 66-step restoring divide on one shared adder, both skipped when clamped or zero-width
// throughput: one item at a time, s_axis_tready low while a query is in work; a finished
// result waits in the output register while the next item is taken
// reset: synchronous active-low aresetn; point_count = 2, clamp_enable = 1, table undefined
module piecewise_linear_interpolator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // x_in[31:0], y_in[63:32]
    input  logic [6:0]  s_axis_tuser,   // op[0], point_index[6:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // y_out[31:0], segment[37:32], zeros
    output logic [3:0]  m_axis_tuser,   // clamp_status[1:0], saturated[2], zero_width[3]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = pli_pkg::DataW;
    localparam int IW = pli_pkg::IdxW;

    // configuration registers
    logic [pli_pkg::CountW-1:0] point_count_reg;
    logic                       clamp_enable_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg  <= 7'd2;
            clamp_enable_reg <= 1'b1;
        end else if (wr_en && paddr[1:0] == 2'b00) begin
            if (paddr[2] == pli_pkg::RegPointCount) begin
                point_count_reg <= pwdata[6:0];
            end else begin
                clamp_enable_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == pli_pkg::RegPointCount) begin
            prdata[6:0] = point_count_reg;
        end else begin
            prdata[0] = clamp_enable_reg;
        end
    end

    // clamped point count and last index
    logic [IW-1:0] last_idx;
    always_comb begin
        if (point_count_reg < 7'd2) begin
            last_idx = IW'(1);
        end else if (point_count_reg > 7'(pli_pkg::MaxPoints)) begin
            last_idx = IW'(pli_pkg::MaxPoints - 1);
        end else begin
            last_idx = IW'(point_count_reg - 7'd1);
        end
    end

    // breakpoint memory, one read port
    logic [2*DW-1:0] table_mem [pli_pkg::MaxPoints];
    logic [IW-1:0]   rd_addr;
    logic [2*DW-1:0] rd_data_reg;
    logic            tbl_we;

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            table_mem[s_axis_tuser[6:1]] <= s_axis_tdata;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    logic signed [DW-1:0] rd_x, rd_y;
    assign rd_x = rd_data_reg[DW-1:0];
    assign rd_y = rd_data_reg[2*DW-1:DW];

    // sequencer state
    pli_pkg::state_t state_reg, state_next;
    logic signed [DW-1:0] xq_reg;
    logic signed [DW-1:0] x0_reg, y0_reg;
    logic signed [DW-1:0] xa_reg, ya_reg;
    logic [IW-1:0]        idx_reg;
    logic [1:0]           status_reg;
    logic [pli_pkg::ProdW-1:0] prod_reg;
    logic [pli_pkg::DivW-1:0]  mc_reg;     // multiplicand magnitude, then divisor
    logic [pli_pkg::DivW-1:0]  mr_reg;     // multiplier magnitude
    logic [pli_pkg::DivW:0]    rem_reg;
    logic [pli_pkg::QuotW-1:0] quot_reg;
    logic                      big_reg;
    logic                      neg_reg;
    logic [6:0]                cnt_reg;
    logic                      out_valid_reg;
    logic [DW-1:0]             out_y_reg;
    logic [1:0]                out_status_reg;
    logic [IW-1:0]             out_seg_reg;
    logic                      out_sat_reg;
    logic                      out_zw_reg;

    assign s_axis_tready = (state_reg == pli_pkg::ST_IDLE);
    assign tbl_we = s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == pli_pkg::OpLoad;

    logic start_q;
    assign start_q = s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == pli_pkg::OpQuery;

    // shared adder: serves multiply accumulate and divide trial subtract
    logic [pli_pkg::DivW:0]   add_a, add_b, add_sum;
    logic                     add_sub;
    assign add_sum = add_sub ? add_a - add_b : add_a + add_b;

    // segment differences (33 bits signed)
    logic signed [DW:0] dx_w, dy_w, dw_w;
    assign dx_w = {xq_reg[DW-1], xq_reg} - {xa_reg[DW-1], xa_reg};
    assign dy_w = {rd_y[DW-1], rd_y} - {ya_reg[DW-1], ya_reg};
    assign dw_w = {rd_x[DW-1], rd_x} - {xa_reg[DW-1], xa_reg};

    function automatic logic [pli_pkg::DivW-1:0] mag33(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        return {1'b0, m};
    endfunction

    // divide: next remainder bit and quotient shift
    logic [pli_pkg::DivW:0] rem_sh;
    logic                   div_ge;
    logic [pli_pkg::ProdW-1:0] prod_sh;
    assign rem_sh = {rem_reg[pli_pkg::DivW-1:0], prod_reg[pli_pkg::ProdW-1]};
    assign div_ge = !add_sum[pli_pkg::DivW] || rem_sh[pli_pkg::DivW];
    assign prod_sh = {prod_reg[pli_pkg::ProdW-2:0], 1'b0};

    always_comb begin
        add_sub = 1'b0;
        add_a   = {1'b0, prod_reg[pli_pkg::ProdW-1:pli_pkg::ProdW-pli_pkg::DivW]};
        add_b   = {1'b0, mc_reg};
        if (state_reg == pli_pkg::ST_DIV) begin
            add_sub = 1'b1;
            add_a   = rem_sh;
            add_b   = {1'b0, mc_reg};
        end
    end

    // final y: ya +/- quotient, then saturate
    logic signed [42:0] res_w;
    logic               q_over;
    assign q_over = big_reg || (quot_reg[pli_pkg::QuotW-1:33] != '0);
    assign res_w = neg_reg ? 43'(ya_reg) - 43'({2'b0, quot_reg})
                           : 43'(ya_reg) + 43'({2'b0, quot_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pli_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == pli_pkg::ST_OUT && !(out_valid_reg && !m_axis_tready)) begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        rd_addr    = idx_reg;
        case (state_reg)
            pli_pkg::ST_IDLE:   if (start_q) state_next = pli_pkg::ST_RD0;
            pli_pkg::ST_RD0:    begin rd_addr = '0; state_next = pli_pkg::ST_RDLAST; end
            pli_pkg::ST_RDLAST: begin rd_addr = last_idx; state_next = pli_pkg::ST_CLASS; end
            pli_pkg::ST_CLASS: begin
                rd_addr = IW'(1);
                state_next = pli_pkg::ST_SEARCH;
            end
            pli_pkg::ST_SEARCH: begin
                if (status_reg != pli_pkg::StatusInside
                    || !(idx_reg < last_idx - IW'(1) && xq_reg >= rd_x)) begin
                    rd_addr    = idx_reg;
                    state_next = pli_pkg::ST_RDSEG;
                end else begin
                    rd_addr = idx_reg + IW'(2);
                end
            end
            pli_pkg::ST_RDSEG: begin rd_addr = idx_reg + IW'(1); state_next = pli_pkg::ST_SETUP; end
            pli_pkg::ST_SETUP: begin
                if ((status_reg != pli_pkg::StatusInside && clamp_enable_reg) || dw_w == '0) begin
                    state_next = pli_pkg::ST_OUT;
                end else begin
                    state_next = pli_pkg::ST_MUL;
                end
            end
            pli_pkg::ST_MUL:    if (cnt_reg == 7'd0) state_next = pli_pkg::ST_DIV;
            pli_pkg::ST_DIV:    if (cnt_reg == 7'd0) state_next = pli_pkg::ST_OUT;
            pli_pkg::ST_OUT:    if (!(out_valid_reg && !m_axis_tready)) state_next = pli_pkg::ST_IDLE;
            default:            state_next = pli_pkg::ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            pli_pkg::ST_IDLE: begin
                xq_reg  <= s_axis_tdata[DW-1:0];
                idx_reg <= '0;
            end
            pli_pkg::ST_RDLAST: begin
                // rd_data holds entry 0
                x0_reg <= rd_x;
                y0_reg <= rd_y;
            end
            pli_pkg::ST_CLASS: begin
                // rd_data holds the last entry
                if (xq_reg <= x0_reg) begin
                    status_reg <= pli_pkg::StatusBelow;
                    idx_reg    <= '0;
                    ya_reg     <= y0_reg;
                end else if (xq_reg >= rd_x) begin
                    status_reg <= pli_pkg::StatusAbove;
                    idx_reg    <= last_idx - IW'(1);
                    ya_reg     <= rd_y;
                end else begin
                    status_reg <= pli_pkg::StatusInside;
                    idx_reg    <= '0;
                end
            end
            pli_pkg::ST_SEARCH: begin
                // rd_data holds entry idx+1
                if (status_reg == pli_pkg::StatusInside
                    && idx_reg < last_idx - IW'(1) && xq_reg >= rd_x) begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            pli_pkg::ST_RDSEG: begin
                // rd_data holds entry idx (left point)
                if (!(status_reg == pli_pkg::StatusAbove && clamp_enable_reg)) begin
                    xa_reg <= rd_x;
                    ya_reg <= rd_y;
                end
            end
            pli_pkg::ST_SETUP: begin
                // rd_data holds entry idx+1 (right point)
                neg_reg  <= ((dx_w < 0) != (dy_w < 0)) != (dw_w < 0);
                mc_reg   <= mag33(dx_w);
                mr_reg   <= mag33(dy_w);
                prod_reg <= '0;
                quot_reg <= '0;
                big_reg  <= 1'b0;
                rem_reg  <= '0;
                cnt_reg  <= 7'd31;
                if (dw_w != '0) begin
                    xa_reg <= DW'(mag33(dw_w));  // divisor magnitude, always below 2^32
                end
            end
            pli_pkg::ST_MUL: begin
                // shift-add from multiplier lsb, product builds at top then shifts down
                prod_reg <= {(mr_reg[0] ? add_sum[pli_pkg::DivW-1:0]
                              : prod_reg[pli_pkg::ProdW-1:pli_pkg::ProdW-pli_pkg::DivW]),
                             prod_reg[pli_pkg::ProdW-pli_pkg::DivW-1:0]} >> 1
                            | (mr_reg[0] ? {add_sum[pli_pkg::DivW], {(pli_pkg::ProdW-1){1'b0}}}
                               : '0);
                mr_reg  <= mr_reg >> 1;
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0) begin
                    mc_reg   <= {2'b0, xa_reg};
                    cnt_reg  <= 7'd65;
                end
            end
            pli_pkg::ST_DIV: begin
                prod_reg <= prod_sh;
                rem_reg  <= div_ge ? add_sum : rem_sh;
                if (quot_reg[pli_pkg::QuotW-1]) begin
                    big_reg <= 1'b1;
                end else begin
                    quot_reg <= {quot_reg[pli_pkg::QuotW-2:0], div_ge};
                end
                cnt_reg <= cnt_reg - 7'd1;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == pli_pkg::ST_OUT && !(out_valid_reg && !m_axis_tready)) begin
            out_status_reg <= status_reg;
            out_seg_reg    <= idx_reg;
            out_zw_reg     <= 1'b0;
            out_sat_reg    <= 1'b0;
            if (status_reg != pli_pkg::StatusInside && clamp_enable_reg) begin
                out_y_reg <= ya_reg;
            end else if (cnt_reg == 7'd31) begin
                out_y_reg  <= ya_reg;
                out_zw_reg <= 1'b1;
            end else if (q_over) begin
                out_sat_reg <= 1'b1;
                out_y_reg   <= (neg_reg && quot_reg != '0) ? 32'h8000_0000 : 32'h7fff_ffff;
            end else if (res_w > 43'sd2147483647) begin
                out_sat_reg <= 1'b1;
                out_y_reg   <= 32'h7fff_ffff;
            end else if (res_w < -43'sd2147483648) begin
                out_sat_reg <= 1'b1;
                out_y_reg   <= 32'h8000_0000;
            end else begin
                out_y_reg <= res_w[DW-1:0];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b0, out_seg_reg, out_y_reg};
    assign m_axis_tuser  = {out_zw_reg, out_sat_reg, out_status_reg};

    // checks
    ap_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != pli_pkg::ST_IDLE |-> !s_axis_tready)
        else $error("ready while busy");
    ap_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        start_q |=> state_reg == pli_pkg::ST_RD0)
        else $error("query not started");
    ap_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
        else $error("bad status");
    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

FILE: tb/sv/pli_checker.sv
`timescale 1ns / 1ps

module pli_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // x_in[31:0], y_in[63:32]
    input  logic [6:0]  s_axis_tuser,   // op[0], point_index[6:1]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // y_out[31:0], segment[37:32], zeros
    input  logic [3:0]  m_axis_tuser,   // clamp_status[1:0], saturated[2], zero_width[3]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          lookups_pending,
    output int          lookups_seen
);

    typedef struct {
        logic [31:0] y;
        logic [1:0]  status;
        logic [5:0]  seg;
        logic        sat;
        logic        zw;
    } lookup_t;

    longint      bp_x [pli_pkg::MaxPoints];
    longint      bp_y [pli_pkg::MaxPoints];
    logic [6:0]  count_reg;
    logic        clamp_reg;
    lookup_t     lookup_q [$];
    int          errors;
    int          seen;

    assign fail_count      = errors;
    assign lookups_pending = lookup_q.size();
    assign lookups_seen    = seen;

    // interpolate, extrapolate or clamp one query x against the current table
    function automatic lookup_t interpolate(longint x);
        lookup_t     r;
        int          n;
        int          i;
        longint      xa, xb, ya, yb, dw, dx, dy, sum;
        logic [127:0] q;
        logic        neg;
        n = count_reg;
        if (n < 2) n = 2;
        if (n > pli_pkg::MaxPoints) n = pli_pkg::MaxPoints;
        i = 0;
        if (x <= bp_x[0]) begin
            r.status = pli_pkg::StatusBelow;
        end else if (x >= bp_x[n-1]) begin
            r.status = pli_pkg::StatusAbove;
            i = n - 2;
        end else begin
            r.status = pli_pkg::StatusInside;
            while (i < n - 2 && x >= bp_x[i+1]) i++;
        end
        r.seg = i[5:0];
        r.sat = 1'b0;
        r.zw  = 1'b0;
        if (r.status != pli_pkg::StatusInside && clamp_reg) begin
            r.y = (r.status == pli_pkg::StatusBelow) ? bp_y[0][31:0] : bp_y[n-1][31:0];
        end else begin
            xa = bp_x[i];
            xb = bp_x[i+1];
            ya = bp_y[i];
            yb = bp_y[i+1];
            dw = xb - xa;
            dx = x - xa;
            dy = yb - ya;
            if (dw == 0) begin
                r.y  = ya[31:0];
                r.zw = 1'b1;
            end else begin
                neg = ((dx < 0) != (dy < 0)) != (dw < 0);
                q = (128'(dx < 0 ? -dx : dx) * 128'(dy < 0 ? -dy : dy))
                    / 128'(dw < 0 ? -dw : dw);
                if (q >= (128'd1 << 33)) begin
                    r.sat = 1'b1;
                    r.y   = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    sum = neg ? ya - longint'(q[63:0]) : ya + longint'(q[63:0]);
                    if (sum > 64'sd2147483647) begin
                        sum   = 64'sd2147483647;
                        r.sat = 1'b1;
                    end
                    if (sum < -64'sd2147483648) begin
                        sum   = -64'sd2147483648;
                        r.sat = 1'b1;
                    end
                    r.y = sum[31:0];
                end
            end
        end
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // track register writes and table loads, queue lookups, compare results
    always @(posedge aclk) begin
        lookup_t exp_r;
        longint  xv;
        if (!aresetn) begin
            foreach (bp_x[k]) begin
                bp_x[k] = 0;
                bp_y[k] = 0;
            end
            count_reg = 7'd2;
            clamp_reg = 1'b1;
            lookup_q.delete();
            errors = 0;
            seen   = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == pli_pkg::RegPointCount) count_reg = pwdata[6:0];
                else clamp_reg = pwdata[0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                xv = longint'($signed(s_axis_tdata[31:0]));
                if (s_axis_tuser[0] == pli_pkg::OpLoad) begin
                    bp_x[s_axis_tuser[6:1]] = xv;
                    bp_y[s_axis_tuser[6:1]] = longint'($signed(s_axis_tdata[63:32]));
                end else begin
                    lookup_q.push_back(interpolate(xv));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen++;
                if (lookup_q.size() == 0) begin
                    $display("unexpected result transfer at %0t: y %h", $realtime,
                             m_axis_tdata[31:0]);
                    errors++;
                end else begin
                    exp_r = lookup_q.pop_front();
                    if (m_axis_tdata[31:0] !== exp_r.y)
                        report("y_out", m_axis_tdata[31:0], exp_r.y);
                    if (m_axis_tuser[1:0] !== exp_r.status)
                        report("clamp_status", 32'(m_axis_tuser[1:0]), 32'(exp_r.status));
                    if (m_axis_tdata[37:32] !== exp_r.seg)
                        report("segment", 32'(m_axis_tdata[37:32]), 32'(exp_r.seg));
                    if (m_axis_tuser[2] !== exp_r.sat)
                        report("saturated", 32'(m_axis_tuser[2]), 32'(exp_r.sat));
                    if (m_axis_tuser[3] !== exp_r.zw)
                        report("zero_width", 32'(m_axis_tuser[3]), 32'(exp_r.zw));
                end
            end
        end
    end

endmodule

FILE: tb/sv/piecewise_linear_interpolator_top_test.sv
`timescale 1ns / 1ps

module piecewise_linear_interpolator_top_test;

    localparam int StallLimit = 5000;
    localparam longint IntMax = 64'sd2147483647;
    localparam longint IntMin = -64'sd2147483648;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // x_in[31:0], y_in[63:32]
    logic [6:0]  s_axis_tuser;   // op[0], point_index[6:1]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // y_out[31:0], segment[37:32], zeros
    logic [3:0]  m_axis_tuser;   // clamp_status[1:0], saturated[2], zero_width[3]
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    int          fail_count, lookups_pending, lookups_seen;
    int          stall_cycles;
    int          loads_sent, queries_sent, phases_run;
    bit          no_idle;
    longint      tab_x [pli_pkg::MaxPoints];

    piecewise_linear_interpolator_top DUT (.*);

    pli_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // no transfer on any channel for too long ends the run
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == StallLimit) begin
            $display("watchdog expired at %0t", $realtime);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint clip32(longint v);
        return v > IntMax ? IntMax : (v < IntMin ? IntMin : v);
    endfunction

    // one input transfer, with a random gap before it
    task automatic send_item(logic op, logic [5:0] idx, longint x, longint y);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y[31:0], x[31:0]};
        s_axis_tuser  <= {idx, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (op == pli_pkg::OpLoad) loads_sent++;
        else queries_sent++;
    endtask

    task automatic load_point(int idx, longint x, longint y);
        tab_x[idx] = x;
        send_item(pli_pkg::OpLoad, idx[5:0], x, y);
    endtask

    task automatic query(longint x);
        send_item(pli_pkg::OpQuery, 6'($urandom), x, longint'($signed($urandom)));
    endtask

    // hold the source until every lookup has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (lookups_pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic which, logic [31:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result side: random stall before each result
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    // stimulus
    initial begin
        int      n, nq, kind, shape, k;
        longint  xv, yv, span;
        logic [31:0] count_val;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_idle = 1'b0;
        loads_sent = 0;
        queries_sent = 0;
        phases_run = 0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, clamp both ends, exact breakpoints
        load_point(0, -262144, IntMax);
        load_point(1, 262144, IntMin);
        query(IntMin);
        query(IntMax);
        query(-262144);
        query(262144);
        query(0);
        query(-1);
        // extrapolation saturating both ways
        write_reg(pli_pkg::RegClampEnable, 32'd0);
        query(IntMin);
        query(IntMax);
        query(1);
        // zero width last segment
        load_point(2, 262144, 12345);
        write_reg(pli_pkg::RegPointCount, 32'd3);
        query(IntMax);
        query(262144);
        query(100000);
        // counts below the legal range saturate to two points
        write_reg(pli_pkg::RegPointCount, 32'd0);
        query(IntMax);
        write_reg(pli_pkg::RegPointCount, 32'd1);
        query(-300000);
        write_reg(pli_pkg::RegClampEnable, 32'd1);
        query(IntMax);

        // random phases: reprogram, reload a table, run lookups
        while (loads_sent + queries_sent < 1950) begin
            phases_run++;
            no_idle = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 6) count_val = $urandom_range(2, 8);
            else if (kind < 8) count_val = $urandom_range(9, 64);
            else if (kind == 8) count_val = $urandom_range(64, 127);
            else count_val = $urandom_range(0, 1);
            n = count_val < 2 ? 2 : (count_val > 64 ? 64 : count_val);
            write_reg(pli_pkg::RegPointCount, count_val);
            write_reg(pli_pkg::RegClampEnable, 32'($urandom_range(0, 1)));
            shape = $urandom_range(0, 7);
            xv = longint'($signed($urandom)) >>> $urandom_range(0, 8);
            for (int p = 0; p < n; p++) begin
                if (shape == 0) xv = longint'($signed($urandom));
                else if (p > 0 && (shape == 1 || $urandom_range(0, 15) == 0))
                    xv = xv;
                else if (p > 0)
                    xv = clip32(xv + $urandom_range(0, 1 << $urandom_range(0, 28)));
                yv = $urandom_range(0, 1) ? longint'($signed($urandom))
                                          : longint'($signed($urandom)) >>> 12;
                load_point(p, xv, yv);
            end
            nq = (n > 16) ? $urandom_range(3, 8) : $urandom_range(5, 40);
            for (int j = 0; j < nq; j++) begin
                k = $urandom_range(0, n - 2);
                case ($urandom_range(0, 9))
                    0: xv = longint'($signed($urandom));
                    1: xv = tab_x[$urandom_range(0, n - 1)];
                    2: xv = clip32(tab_x[k] + ($urandom_range(0, 1) ? 1 : -1));
                    3: xv = clip32(tab_x[0] - $urandom_range(0, 1 << $urandom_range(0, 30)));
                    4: xv = clip32(tab_x[n-1] + $urandom_range(0, 1 << $urandom_range(0, 30)));
                    default: begin
                        span = tab_x[k+1] - tab_x[k];
                        xv = (span <= 0) ? tab_x[k]
                                         : tab_x[k] + longint'($urandom) % (span + 1);
                    end
                endcase
                query(xv);
                // occasional reload of a point while lookups are in flight
                if ($urandom_range(0, 19) == 0)
                    load_point($urandom_range(0, n - 1), longint'($signed($urandom)),
                               longint'($signed($urandom)));
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("covered %0d table loads and %0d lookups over %0d table settings",
                 loads_sent, queries_sent, phases_run);
        $display("%0d results checked, clamp and extrapolation at both ends", lookups_seen);
        if (fail_count == 0 && lookups_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: piecewise_linear_interpolator_top.f
rtl/pli_pkg.sv
rtl/piecewise_linear_interpolator_top.sv
tb/sv/pli_checker.sv
tb/sv/piecewise_linear_interpolator_top_test.sv
